>>> rtl/fita_pkg.sv
// Shared types and constants for the free ID allocator tree.
package fita_pkg;

  // Command codes on the cmd field
  localparam logic [1:0] CMD_GET     = 2'd0;
  localparam logic [1:0] CMD_CHECK   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  // Register index, taken from paddr[2]
  localparam logic REG_MAX_NUMBERS = 1'b0;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DOWN,
    ST_WB,
    ST_UP,
    ST_OUT
  } fita_state_t;

  // Control shared by every level cell
  typedef struct packed {
    logic sweep;   // rebuild pass: write the reset pattern
    logic follow;  // descend along the given ID instead of the lowest free one
  } fita_ctrl_t;

endpackage

>>> rtl/fita_cell.sv
// One tree level: the child pairs of all nodes at level K, with descent and refresh handoff.
module fita_cell #(
  parameter int K      = 0,
  parameter int LEVELS = 10,
  parameter int LIM_W  = 11,
  parameter int SW     = 9,
  localparam int AW    = (K > 0) ? K : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  fita_pkg::fita_ctrl_t ctrl,
  input  logic [LIM_W-1:0]    limit,
  input  logic [SW-1:0]       sidx,
  input  logic                dir,
  input  logic                go_in,
  input  logic [AW-1:0]       node_in,
  output logic                go_out,
  output logic [K:0]          node_out,
  output logic                hit,
  input  logic                up_in_vld,
  input  logic                up_in_val,
  output logic                up_out_vld,
  output logic                up_out_val
);
  import fita_pkg::*;

  localparam int DEPTH = 1 << AW;
  localparam int SH    = LEVELS - 1 - K;
  localparam int CW    = LEVELS + 1;

  // bit 0 is the left child, bit 1 the right child
  logic [1:0]    mem [DEPTH];
  logic [1:0]    rdata;
  logic [AW-1:0] node_reg;
  logic          pend;
  logic          side;
  logic          c;
  logic [1:0]    pair_new;
  logic [1:0]    sweep_pair;
  logic [CW-1:0] sw_base;
  logic [CW-1:0] node_lo;
  logic [CW-1:0] node_hi;
  logic          we;
  logic [AW-1:0] waddr;
  logic [1:0]    wdata;

  // reset pattern: a node is free if its first leaf lies below the limit
  assign sw_base    = (K > 0) ? (CW'(sidx[AW-1:0]) << 1) : '0;
  assign node_lo    = sw_base << SH;
  assign node_hi    = (sw_base | CW'(1)) << SH;
  assign sweep_pair = {node_hi < CW'(limit), node_lo < CW'(limit)};

  // direction: left when free, or the ID's own bit
  assign c        = ctrl.follow ? dir : ~rdata[0];
  assign hit      = rdata[c];
  assign go_out   = pend;
  assign node_out = (K + 1)'({node_reg, c});

  // refresh: replace the chosen child with the value from below
  assign pair_new = side ? {up_in_val, rdata[0]} : {rdata[1], up_in_val};

  assign we    = ctrl.sweep | up_in_vld;
  assign waddr = ctrl.sweep ? sidx[AW-1:0] : node_reg;
  assign wdata = ctrl.sweep ? sweep_pair : pair_new;

  // pair memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (go_in && !ctrl.sweep) begin
      rdata <= mem[node_in];
    end
  end

  // path node and chosen side, held for the refresh
  always_ff @(posedge clk) begin
    if (go_in) begin
      node_reg <= node_in;
    end
    if (pend) begin
      side <= c;
    end
    up_out_val <= |pair_new;
  end

  // handoff strobes
  always_ff @(posedge clk) begin
    if (rst) begin
      pend       <= 1'b0;
      up_out_vld <= 1'b0;
    end else begin
      pend       <= go_in & ~ctrl.sweep;
      up_out_vld <= up_in_vld & ~ctrl.sweep;
    end
  end

endmodule

>>> rtl/free_id_allocator_tree.sv
// Top level of the free ID allocator: level cell chain, sequencer, register port.
//
// Hands out the lowest free ID below max_numbers (cmd get), tests one ID (check) or
// frees one (release); every accepted word gives exactly one result word. The tree
// lives in a chain of LEVELS = clog2(NUM_IDS) cells, one per level, each holding the
// child pairs of its level in a small memory. A command walks down the chain one
// level per cycle and, when it changes a leaf, refreshes the ancestors back up the
// chain one level per cycle. A check, a failed get, an out-of-range release or an
// unused command only walks down before its result is loaded; a granted get or an
// in-range release also writes the leaf and refreshes back up to the root first.
// One command is in flight at a time; a result may wait in the output register
// while the next word is taken. After reset and after every write of max_numbers the
// tree is rebuilt by a sweep pass over every node index with in_stall high, after
// which every ID below the limit is free.
module free_id_allocator_tree #(
  parameter int  NUM_IDS = 1024,
  localparam int ID_W    = $clog2(NUM_IDS),
  localparam int LIM_W   = $clog2(NUM_IDS + 1)
) (
  input  logic            clk,
  input  logic            rst,
  // command channel
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      cmd,
  input  logic [ID_W-1:0] number,
  // result channel
  output logic            out_valid,
  input  logic            out_stall,
  output logic [ID_W-1:0] number_out,
  output logic            ok,
  // register port
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import fita_pkg::*;

  localparam int LEVELS = ID_W;
  localparam int SW     = (LEVELS > 1) ? LEVELS - 1 : 1;

  fita_state_t       state, state_next;
  fita_ctrl_t        ctrl;
  logic [SW-1:0]     cnt;
  logic [LIM_W-1:0]  max_numbers;
  logic [LIM_W-1:0]  limit;
  logic              cfg_wr;
  logic              acc;
  logic [1:0]        cmd_reg;
  logic [ID_W-1:0]   number_reg;
  logic              in_range;
  logic [ID_W-1:0]   res_num;
  logic              res_ok;
  logic              wb_val;
  logic              out_load;
  logic              up_start;

  // leaf evaluation
  logic              ev_ok;
  logic              ev_wr;
  logic              ev_val;
  logic [ID_W-1:0]   ev_num;

  // chain handoff
  logic [LEVELS:0]   dn_go;
  logic [LEVELS-1:0] dn_node [1:LEVELS];
  logic [LEVELS-1:0] hit_vec;
  logic [LEVELS:0]   up_v;
  logic [LEVELS:0]   up_val;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_MAX_NUMBERS);
  assign prdata = (paddr[2] == REG_MAX_NUMBERS) ? 32'(max_numbers) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_numbers <= LIM_W'(NUM_IDS);
    end else if (cfg_wr) begin
      max_numbers <= pwdata[LIM_W-1:0];
    end
  end

  // limits above the ID count saturate
  assign limit    = (max_numbers > LIM_W'(NUM_IDS)) ? LIM_W'(NUM_IDS) : max_numbers;
  assign in_range = LIM_W'(number_reg) < limit;

  // rebuild sweep counter
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      cnt <= '0;
    end else if (state == ST_SWEEP) begin
      cnt <= cnt + 1'b1;
    end
  end

  // command capture
  assign acc = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_reg    <= cmd;
      number_reg <= number;
    end
  end

  // outcome at the leaf cell
  always_comb begin
    ev_ok  = 1'b0;
    ev_wr  = 1'b0;
    ev_val = 1'b0;
    ev_num = number_reg;
    unique case (cmd_reg)
      CMD_GET: begin
        ev_ok  = hit_vec[LEVELS-1];
        ev_wr  = hit_vec[LEVELS-1];
        ev_num = hit_vec[LEVELS-1] ? dn_node[LEVELS] : '0;
      end
      CMD_CHECK: begin
        ev_ok = in_range & hit_vec[LEVELS-1];
      end
      CMD_RELEASE: begin
        ev_ok  = in_range;
        ev_wr  = in_range;
        ev_val = 1'b1;
      end
      default: begin
        ev_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_DOWN && dn_go[LEVELS]) begin
      res_num <= ev_num;
      res_ok  <= ev_ok;
      wb_val  <= ev_val;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    if (cfg_wr) begin
      state_next = ST_SWEEP;
    end else begin
      unique case (state)
        ST_SWEEP: if (cnt == '1) state_next = ST_IDLE;
        ST_IDLE:  if (acc) state_next = ST_DOWN;
        ST_DOWN: begin
          if (dn_go[LEVELS]) state_next = ev_wr ? ST_WB : ST_OUT;
        end
        ST_WB:    state_next = ST_UP;
        ST_UP:    if (up_v[0]) state_next = ST_OUT;
        ST_OUT:   if (out_load) state_next = ST_IDLE;
        default:  state_next = ST_IDLE;
      endcase
    end
  end

  // state outputs
  always_comb begin
    in_stall    = (state != ST_IDLE);
    ctrl.sweep  = (state == ST_SWEEP);
    ctrl.follow = (cmd_reg != CMD_GET);
    up_start    = (state == ST_WB);
    out_load    = (state == ST_OUT) && (!out_valid || !out_stall);
  end

  // chain ends
  assign dn_go[0]       = acc;
  assign up_v[LEVELS]   = up_start;
  assign up_val[LEVELS] = wb_val;

  // level cells, root first
  for (genvar k = 0; k < LEVELS; k++) begin : g_cell
    localparam int AW = (k > 0) ? k : 1;
    logic [AW-1:0] node_i;
    logic [k:0]    node_o;

    if (k == 0) begin : g_root
      assign node_i = '0;
    end else begin : g_inner
      assign node_i = dn_node[k][AW-1:0];
    end

    assign dn_node[k+1] = LEVELS'(node_o);

    fita_cell #(
      .K      (k),
      .LEVELS (LEVELS),
      .LIM_W  (LIM_W),
      .SW     (SW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .limit      (limit),
      .sidx       (cnt),
      .dir        (number_reg[LEVELS-1-k]),
      .go_in      (dn_go[k]),
      .node_in    (node_i),
      .go_out     (dn_go[k+1]),
      .node_out   (node_o),
      .hit        (hit_vec[k]),
      .up_in_vld  (up_v[k+1]),
      .up_in_val  (up_val[k+1]),
      .up_out_vld (up_v[k]),
      .up_out_val (up_val[k])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      number_out <= res_num;
      ok         <= res_ok;
    end
  end

endmodule

>>> test/tb_free_id_allocator_tree.sv
// Self-checking testbench for the free ID allocator tree.
`timescale 1ns / 1ps

module tb_free_id_allocator_tree;
  import fita_pkg::*;

  localparam int NUM_IDS = 1024;
  localparam int ID_W    = 10;
  localparam int LIM_W   = 11;
  // cmd value the block does not decode
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // longest accept-to-accept time is that of a granted get or an in-range release; leave margin
  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    logic [1:0]      op;
    logic [ID_W-1:0] id;
  } cmd_word_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            granted;
  } reply_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [1:0]      cmd = CMD_GET;
  logic [ID_W-1:0] number = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [ID_W-1:0] number_out;
  logic            ok;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [2:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;

  free_id_allocator_tree #(.NUM_IDS(NUM_IDS)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .number     (number),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .number_out (number_out),
    .ok         (ok),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  // Command words waiting to be sent, and replies waiting to come back
  cmd_word_t   cmd_q[$];
  reply_t      reply_q[$];
  cmd_word_t   next_word;
  int unsigned mismatches = 0;

  // Idle control: rate changes now and then, zero in the closing phase
  bit          calm = 1'b0;
  int unsigned idle_pct = 0;
  int unsigned mode_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  // Predicted availability tree, 1-based heap, leaves at NUM_IDS + id
  bit          avail [1:2*NUM_IDS-1];
  int unsigned id_limit;

  // Shadow of what the queued words will have allocated, for stimulus only
  bit          held [NUM_IDS];
  int          held_cnt;
  int unsigned plan_limit;

  function automatic void rebuild_tree(input logic [LIM_W-1:0] raw);
    id_limit = (raw > NUM_IDS) ? NUM_IDS : raw;
    for (int i = 0; i < NUM_IDS; i++) avail[NUM_IDS + i] = (i < id_limit);
    for (int i = NUM_IDS - 1; i >= 1; i--) avail[i] = avail[2*i] | avail[2*i+1];
  endfunction

  function automatic void refresh_ancestors(input int unsigned leaf);
    int unsigned node;
    node = leaf;
    while (node > 1) begin
      node = node >> 1;
      avail[node] = avail[2*node] | avail[2*node+1];
    end
  endfunction

  // Apply one command to the predicted tree and return the reply it gives
  function automatic void allocator_step(input logic [1:0] op, input logic [ID_W-1:0] id,
                                         output logic [ID_W-1:0] id_out,
                                         output logic granted);
    int unsigned node;
    id_out  = id;
    granted = 1'b0;
    case (op)
      CMD_GET: begin
        id_out = '0;
        if (avail[1]) begin
          node = 1;
          while (node < NUM_IDS) node = avail[2*node] ? 2*node : 2*node + 1;
          avail[node] = 1'b0;
          refresh_ancestors(node);
          id_out  = ID_W'(node - NUM_IDS);
          granted = 1'b1;
        end
      end
      CMD_CHECK: begin
        granted = (id < id_limit) && avail[NUM_IDS + id];
      end
      CMD_RELEASE: begin
        if (id < id_limit) begin
          avail[NUM_IDS + id] = 1'b1;
          refresh_ancestors(NUM_IDS + id);
          granted = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void reset_plan(input logic [LIM_W-1:0] raw);
    plan_limit = (raw > NUM_IDS) ? NUM_IDS : raw;
    held_cnt = 0;
    for (int i = 0; i < NUM_IDS; i++) held[i] = 1'b0;
  endfunction

  // Queue a word and track which IDs it leaves allocated
  function automatic void plan_cmd(input logic [1:0] op, input logic [ID_W-1:0] id);
    int unsigned i;
    if (op == CMD_GET) begin
      i = 0;
      while (i < plan_limit && held[i]) i++;
      if (i < plan_limit) begin
        held[i] = 1'b1;
        held_cnt++;
      end
    end else if (op == CMD_RELEASE && id < plan_limit && held[id]) begin
      held[id] = 1'b0;
      held_cnt--;
    end
    cmd_q.push_back('{op, id});
  endfunction

  // Random ID currently allocated; only called with held_cnt > 0
  function automatic logic [ID_W-1:0] pick_held();
    int unsigned i;
    i = $urandom_range(0, plan_limit - 1);
    while (!held[i]) i = (i + 1) % plan_limit;
    return ID_W'(i);
  endfunction

  // Mostly gets and releases of allocated IDs, some checks, the rest noise
  function automatic void plan_random(input int unsigned get_w);
    int unsigned     r;
    logic [ID_W-1:0] id;
    r  = $urandom_range(0, 99);
    id = ID_W'($urandom_range(0, NUM_IDS - 1));
    if (r < get_w) begin
      plan_cmd(CMD_GET, id);
    end else if (r < get_w + 28) begin
      if (held_cnt > 0 && $urandom_range(0, 99) < 85) id = pick_held();
      plan_cmd(CMD_RELEASE, id);
    end else if (r < get_w + 45) begin
      if (held_cnt > 0 && $urandom_range(0, 1) == 1) id = pick_held();
      else if (plan_limit > 0 && $urandom_range(0, 1) == 1)
        id = ID_W'($urandom_range(0, plan_limit - 1));
      plan_cmd(CMD_CHECK, id);
    end else begin
      plan_cmd(2'($urandom_range(0, 3)), id);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic wait_drained();
    while (cmd_q.size() != 0 || in_valid || reply_q.size() != 0) @(negedge clk);
  endtask

  // Register write while idle: drain, let the last refresh finish, write, rebuild
  task automatic set_max_numbers(input logic [LIM_W-1:0] val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MAX_NUMBERS, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    rebuild_tree(val);
    reset_plan(val);
    @(negedge clk);
  endtask

  // Idle rate: none, light or heavy, picked anew whenever the mode counter runs out
  always @(posedge clk) begin
    if (mode_left == 0) begin
      case ($urandom_range(0, 2))
        0:       idle_pct <= 0;
        1:       idle_pct <= 12;
        default: idle_pct <= 35;
      endcase
      mode_left <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
  end

  // Command driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_q.size() != 0 && !calm && $urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        gap_left <= $urandom_range(0, 2);
      end else if (cmd_q.size() != 0) begin
        next_word = cmd_q.pop_front();
        in_valid <= 1'b1;
        cmd      <= next_word.op;
        number   <= next_word.id;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall in bursts of random length, started at the idle rate
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: check the result word, then predict for the accepted word
  always @(posedge clk) begin
    reply_t          want;
    logic [ID_W-1:0] p_id;
    logic            p_ok;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("result id %0d ok %0b with nothing expected",
                                    number_out, ok));
        end else begin
          want = reply_q.pop_front();
          if (number_out !== want.id)
            report_mismatch($sformatf("number_out %0d, expected %0d", number_out, want.id));
          if (ok !== want.granted)
            report_mismatch($sformatf("ok %0b, expected %0b (id %0d)",
                                      ok, want.granted, want.id));
        end
      end
      if (in_valid && !in_stall) begin
        allocator_step(cmd, number, p_id, p_ok);
        reply_q.push_back('{p_id, p_ok});
      end
    end
  end

  // Stimulus
  initial begin
    logic [LIM_W-1:0] lim;
    int unsigned      get_w;
    rebuild_tree(LIM_W'(NUM_IDS));
    reset_plan(LIM_W'(NUM_IDS));

    // full range: grants from zero, double release, unused command
    plan_cmd(CMD_CHECK, 10'd0);
    plan_cmd(CMD_GET, 10'd0);
    plan_cmd(CMD_GET, 10'h3FF);
    plan_cmd(CMD_CHECK, 10'd1);
    plan_cmd(CMD_RELEASE, 10'd1);
    plan_cmd(CMD_RELEASE, 10'd1);
    plan_cmd(CMD_CHECK, 10'd1023);
    plan_cmd(CMD_UNUSED, 10'd1023);
    plan_cmd(CMD_GET, 10'd0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // small range: exhaust, out-of-range check and release, refill
    set_max_numbers(11'd5);
    repeat (6) plan_cmd(CMD_GET, 10'd0);
    plan_cmd(CMD_CHECK, 10'd5);
    plan_cmd(CMD_RELEASE, 10'd1023);
    plan_cmd(CMD_RELEASE, 10'd3);
    plan_cmd(CMD_GET, 10'd0);

    // empty range
    set_max_numbers(11'd0);
    plan_cmd(CMD_GET, 10'd0);
    plan_cmd(CMD_RELEASE, 10'd0);

    // limit above the ID count saturates
    set_max_numbers(11'd2047);
    plan_cmd(CMD_CHECK, 10'd1023);
    plan_cmd(CMD_GET, 10'd0);

    // single ID
    set_max_numbers(11'd1);
    plan_cmd(CMD_GET, 10'd0);
    plan_cmd(CMD_GET, 10'd0);

    // random phases, small ranges most often so the tree fills and drains
    for (int p = 0; p < 10; p++) begin
      case (p % 5)
        0:       lim = LIM_W'($urandom_range(1, 24));
        1:       lim = LIM_W'(NUM_IDS);
        2:       lim = LIM_W'($urandom_range(0, 2047));
        3:       lim = LIM_W'($urandom_range(25, 200));
        default: lim = 11'd2047;
      endcase
      if (p == 9) lim = LIM_W'($urandom_range(4, 40));
      set_max_numbers(lim);
      if (p == 9) calm = 1'b1;
      get_w = $urandom_range(25, 45);
      repeat (183) plan_random(get_w);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
rtl/fita_pkg.sv
rtl/fita_cell.sv
rtl/free_id_allocator_tree.sv
test/tb_free_id_allocator_tree.sv
